### src/pcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants and types for the Post class membership block.
// No dependencies; used by post_class_membership.
package pcm_pkg;

	localparam int MAX_VARS    = 8;
	localparam int TABLE_DEPTH = 1 << MAX_VARS;
	localparam int ADDR_W      = MAX_VARS;
	localparam int VAR_W       = 4;
	localparam int SUB_W       = $clog2(MAX_VARS + 1);

	localparam logic [VAR_W-1:0] VAR_RESET = 4'd3;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_WALK,
		ST_DRAIN,
		ST_REPORT
	} state_t;

endpackage
`default_nettype wire

### src/pcm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic RAM: one write port, two read ports with registered read data.
// Standalone; no package dependencies.
module pcm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic      [WIDTH-1:0]         rd_data_a,
	output logic      [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule
`default_nettype wire

### src/post_class_membership.sv
`timescale 1ns / 1ps
`default_nettype none
// Post class membership test (T0, T1, self-dual, monotone, linear) of a truth table.
// Depends on pcm_pkg and pcm_ram.
//
// channel   direction  handshake              payload
// in        sink       in_valid / in_stall    truth_value
// out       source     out_valid / out_stall  preserves_zero .. linear
// cfg       sink       cfg_valid / cfg_ready  var_count
//
// Each row is written to the RAM on its transfer. After the last of 2^n rows the
// stored table is walked through the RAM read ports, n+1 reads per row, then the
// DRAIN and REPORT states follow; in_stall is high through the walk and those states.
// The result sits in the output register; loading of the next table proceeds while it
// waits, stalling only at that table's last row. in_stall is also high while a
// configuration transfer is offered. arst_n clears the row counter and sets n to 3.
module post_class_membership (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      truth_value,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           preserves_zero,
	output logic                           preserves_one,
	output logic                           self_dual,
	output logic                           monotone,
	output logic                           linear,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [pcm_pkg::VAR_W-1:0] var_count
);

	pcm_pkg::state_t state_q, state_d;

	logic [pcm_pkg::VAR_W-1:0]  var_q;
	logic [pcm_pkg::SUB_W-1:0]  n_eff;
	logic [pcm_pkg::ADDR_W-1:0] full_mask;
	logic [pcm_pkg::ADDR_W-1:0] row_q;
	logic [pcm_pkg::ADDR_W-1:0] x_q;
	logic [pcm_pkg::SUB_W-1:0]  sub_q;
	logic [pcm_pkg::ADDR_W-1:0] addr_b;
	logic [pcm_pkg::ADDR_W-1:0] basis_q;
	logic [pcm_pkg::ADDR_W-1:0] x_s1;
	logic                       chk_s1, cmpl_s1;
	logic                       rd_a, rd_b, pred;
	logic                       t0_q, t1_q, sd_q, mono_q, lin_q;
	logic                       out_valid_q;
	logic                       in_xfer, cfg_xfer, last_row, last_issue;

	assign n_eff = (var_q > pcm_pkg::VAR_W'(pcm_pkg::MAX_VARS))
		? pcm_pkg::SUB_W'(pcm_pkg::MAX_VARS) : pcm_pkg::SUB_W'(var_q);
	assign full_mask  = ~({pcm_pkg::ADDR_W{1'b1}} << n_eff);
	assign last_row   = (row_q == full_mask);
	assign last_issue = (x_q == full_mask) && (sub_q == n_eff);
	assign addr_b     = (sub_q == '0) ? (~x_q & full_mask)
		: (x_q | (pcm_pkg::ADDR_W'(1) << (sub_q - 1'b1)));
	assign in_xfer    = in_valid && !in_stall;
	assign cfg_xfer   = cfg_valid && cfg_ready;
	assign pred       = ~t0_q ^ (^(x_s1 & (basis_q ^ {pcm_pkg::ADDR_W{~t0_q}})));

	pcm_ram #(
		.WIDTH(1),
		.DEPTH(pcm_pkg::TABLE_DEPTH)
	) u_table (
		.clk      (clk),
		.wr_en    (in_xfer),
		.wr_addr  (row_q),
		.wr_data  (truth_value),
		.rd_addr_a(x_q),
		.rd_addr_b(addr_b),
		.rd_data_a(rd_a),
		.rd_data_b(rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcm_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		unique case (state_q)
			pcm_pkg::ST_LOAD: begin
				in_stall  = (out_valid_q && last_row) || cfg_valid;
				cfg_ready = 1'b1;
				if (in_valid && !in_stall && last_row && !cfg_valid) begin
					state_d = pcm_pkg::ST_WALK;
				end
			end
			pcm_pkg::ST_WALK: begin
				if (last_issue) begin
					state_d = pcm_pkg::ST_DRAIN;
				end
			end
			pcm_pkg::ST_DRAIN: begin
				state_d = pcm_pkg::ST_REPORT;
			end
			pcm_pkg::ST_REPORT: begin
				state_d = pcm_pkg::ST_LOAD;
			end
			default: begin
				state_d = pcm_pkg::ST_LOAD;
			end
		endcase
	end

	// Row counter and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_q  <= pcm_pkg::VAR_RESET;
			row_q  <= '0;
			chk_s1 <= 1'b0;
		end else begin
			chk_s1 <= (state_q == pcm_pkg::ST_WALK);
			if (cfg_xfer) begin
				var_q <= var_count;
				row_q <= '0;
			end else if (in_xfer) begin
				row_q <= last_row ? '0 : row_q + 1'b1;
			end
		end
	end

	// Capture T0/T1 and the unit-vector rows; advance the walk and update the class flags.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			if (row_q == '0) begin
				t0_q <= ~truth_value;
			end
			for (int i = 0; i < pcm_pkg::ADDR_W; i++) begin
				if (row_q == (pcm_pkg::ADDR_W'(1) << i)) begin
					basis_q[i] <= truth_value;
				end
			end
			if (last_row) begin
				t1_q   <= truth_value;
				x_q    <= '0;
				sub_q  <= '0;
				sd_q   <= 1'b1;
				mono_q <= 1'b1;
				lin_q  <= 1'b1;
			end
		end
		if (state_q == pcm_pkg::ST_WALK) begin
			if (sub_q == n_eff) begin
				sub_q <= '0;
				x_q   <= x_q + 1'b1;
			end else begin
				sub_q <= sub_q + 1'b1;
			end
		end
		cmpl_s1 <= (sub_q == '0);
		x_s1    <= x_q;
		if (chk_s1) begin
			if (cmpl_s1) begin
				if (rd_a == rd_b) begin
					sd_q <= 1'b0;
				end
				if (rd_a != pred) begin
					lin_q <= 1'b0;
				end
			end else if (rd_a && !rd_b) begin
				mono_q <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pcm_pkg::ST_REPORT) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pcm_pkg::ST_REPORT) begin
			preserves_zero <= t0_q;
			preserves_one  <= t1_q;
			self_dual      <= sd_q;
			monotone       <= mono_q;
			linear         <= lin_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### src/pcm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks on the Post class membership block, bound to its top level.
// Depends on post_class_membership.
module pcm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic preserves_zero,
	input wire logic preserves_one,
	input wire logic self_dual,
	input wire logic monotone,
	input wire logic linear,
	input wire logic cfg_ready
);

	// A new result appears only after a walk, which holds the input stalled.
	a_result_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a preceding walk");

	// A self-dual function maps all-zero and all-one rows to opposite values.
	a_self_dual_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && self_dual |-> preserves_zero == preserves_one)
		else $error("self-dual result with inconsistent T0/T1");

	// A monotone function with f(0..0)=1 is constant one.
	a_monotone_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && monotone && !preserves_zero |-> preserves_one)
		else $error("monotone result with f(0)=1 and f(1)=0");

	// Hold the result while the receiver stalls.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(preserves_zero)
			&& $stable(preserves_one) && $stable(self_dual)
			&& $stable(monotone) && $stable(linear))
		else $error("stalled result changed");

	// Busy for configuration means busy for input too.
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> in_stall)
		else $error("input open during walk");

endmodule

bind post_class_membership pcm_checker u_pcm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.preserves_zero(preserves_zero),
	.preserves_one (preserves_one),
	.self_dual     (self_dual),
	.monotone      (monotone),
	.linear        (linear),
	.cfg_ready     (cfg_ready)
);
`default_nettype wire
